// ===== rtl/core/sbck_pkg.sv =====
// Shared types, constants and helpers for the colour-keyed sprite blitter.
// No dependencies; used by every module under rtl/core but sbck_checker.
package sbck_pkg;

   localparam int MAX_SPRITE_DIM = 1024;
   localparam int MAX_SCREEN_DIM = 2048;
   localparam logic [15:0] KEY_COLOUR = 16'd63519;

   localparam int DIM_W   = 12;     // holds every clamped dimension
   localparam int CNT_W   = 10;     // column / row counters
   localparam int POS_W   = 14;     // signed screen coordinates with headroom
   localparam int COORD_W = 11;     // on-screen coordinate, below MAX_SCREEN_DIM
   localparam int DEST_W  = 22;
   localparam int PIX_W   = 16;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // register indexes
   localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_POS_X         = 3'd2;
   localparam logic [2:0] REG_POS_Y         = 3'd3;
   localparam logic [2:0] REG_ALIGNMENT     = 3'd4;
   localparam logic [2:0] REG_OPERATION     = 3'd5;
   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd6;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd7;

   localparam logic [1:0] ALIGN_LEFT   = 2'd0;
   localparam logic [1:0] ALIGN_CENTRE = 2'd1;
   localparam logic [1:0] ALIGN_END    = 2'd2;

   localparam logic [1:0] OP_KEY_DISPLAY = 2'd0;
   localparam logic [1:0] OP_KEY_BACK    = 2'd1;
   localparam logic [1:0] OP_OPAQUE      = 2'd2;
   localparam logic [1:0] OP_COLLIDE     = 2'd3;

   localparam logic [1:0] BUF_THIRD = 2'd2;

   typedef struct packed {
      logic [10:0]       sprite_width;
      logic [10:0]       sprite_height;
      logic signed [11:0] pos_x;
      logic signed [11:0] pos_y;
      logic [1:0]        alignment;
      logic [1:0]        operation;
      logic [11:0]       screen_width;
      logic [11:0]       screen_height;
   } cfg_type;

   // one classified pixel, front to back
   typedef struct packed {
      logic               visible;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               write_enable;
      logic [1:0]         buffer_id;
      logic [PIX_W-1:0]   pixel;
      logic               hit;        // collision candidate
      logic               first;      // first pixel of a sprite
      logic               off_screen;
      logic               last;
   } entry_type;

   // 0 counts as 1, anything above limit saturates
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] limit);
      logic [DIM_W-1:0] r;
      if (v == '0)
         r = DIM_W'(1);
      else if (v > limit)
         r = limit;
      else
         r = v;
      return r;
   endfunction

endpackage

// ===== rtl/core/sbck_front.sv =====
// Front end: pixel counters, alignment, clipping and key classification.
// Depends on sbck_pkg; feeds sbck_queue.
module sbck_front (
   input  logic                clock,
   input  logic                reset,
   input  sbck_pkg::cfg_type   cfg,
   input  logic                accept,
   input  logic [15:0]         sprite_pixel,
   input  logic [15:0]         background_pixel,
   output sbck_pkg::entry_type entry
);

   logic [sbck_pkg::CNT_W-1:0] col_cnt_ff, col_cnt_in;
   logic [sbck_pkg::CNT_W-1:0] row_cnt_ff, row_cnt_in;

   logic [sbck_pkg::DIM_W-1:0] w, h, sw, sh, shift;
   logic signed [sbck_pkg::POS_W-1:0] x, y, ws, hs, sws, shs, col, row;
   logic visible, off, spr_opaque, bg_opaque, col_wrap, row_wrap, last;

   always_comb begin
      w  = sbck_pkg::clamp_dim({1'b0, cfg.sprite_width},
                               sbck_pkg::DIM_W'(sbck_pkg::MAX_SPRITE_DIM));
      h  = sbck_pkg::clamp_dim({1'b0, cfg.sprite_height},
                               sbck_pkg::DIM_W'(sbck_pkg::MAX_SPRITE_DIM));
      sw = sbck_pkg::clamp_dim(cfg.screen_width,
                               sbck_pkg::DIM_W'(sbck_pkg::MAX_SCREEN_DIM));
      sh = sbck_pkg::clamp_dim(cfg.screen_height,
                               sbck_pkg::DIM_W'(sbck_pkg::MAX_SCREEN_DIM));

      ws  = $signed({2'b00, w});
      hs  = $signed({2'b00, h});
      sws = $signed({2'b00, sw});
      shs = $signed({2'b00, sh});

      // collision mode ignores alignment
      shift = '0;
      if (cfg.operation != sbck_pkg::OP_COLLIDE) begin
         if (cfg.alignment == sbck_pkg::ALIGN_CENTRE)
            shift = w >> 1;
         else if (cfg.alignment == sbck_pkg::ALIGN_END)
            shift = w;
      end

      x = sbck_pkg::POS_W'(cfg.pos_x) - $signed({2'b00, shift});
      y = sbck_pkg::POS_W'(cfg.pos_y);

      off = (x + ws <= 0) || (x >= sws) || (y + hs <= 0) || (y >= shs);

      // stream rows run bottom-up
      col = x + $signed({4'b0000, col_cnt_ff});
      row = y + hs - sbck_pkg::POS_W'(1) - $signed({4'b0000, row_cnt_ff});
      visible = !col[sbck_pkg::POS_W-1] && (col < sws) &&
                !row[sbck_pkg::POS_W-1] && (row < shs);

      spr_opaque = sprite_pixel != sbck_pkg::KEY_COLOUR;
      bg_opaque  = background_pixel != sbck_pkg::KEY_COLOUR;

      col_wrap = {2'b00, col_cnt_ff} >= (w - sbck_pkg::DIM_W'(1));
      row_wrap = {2'b00, row_cnt_ff} >= (h - sbck_pkg::DIM_W'(1));
      last     = col_wrap && row_wrap;

      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (col_wrap) begin
         col_cnt_in = '0;
         row_cnt_in = row_wrap ? '0 : row_cnt_ff + sbck_pkg::CNT_W'(1);
      end else begin
         col_cnt_in = col_cnt_ff + sbck_pkg::CNT_W'(1);
      end

      entry.visible    = visible;
      entry.row        = row[sbck_pkg::COORD_W-1:0];
      entry.col        = col[sbck_pkg::COORD_W-1:0];
      entry.pixel      = sprite_pixel;
      entry.first      = (col_cnt_ff == '0) && (row_cnt_ff == '0);
      entry.off_screen = off;
      entry.last       = last;
      entry.hit        = 1'b0;
      case (cfg.operation)
         sbck_pkg::OP_COLLIDE: begin
            entry.write_enable = 1'b0;
            entry.hit          = visible && spr_opaque && bg_opaque;
         end
         sbck_pkg::OP_OPAQUE: entry.write_enable = visible;
         default:             entry.write_enable = visible && spr_opaque;
      endcase
      entry.buffer_id = (cfg.operation >= sbck_pkg::OP_OPAQUE) ? sbck_pkg::BUF_THIRD
                                                               : cfg.operation;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (accept) begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

endmodule

// ===== rtl/core/sbck_queue.sv =====
// Short FIFO of classified pixels between front end and back end.
// Depends on sbck_pkg.
module sbck_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sbck_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output sbck_pkg::entry_type head
);

   sbck_pkg::entry_type store_ff [sbck_pkg::QDEPTH];
   logic [sbck_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [sbck_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full  = count_ff == sbck_pkg::QCNT_W'(sbck_pkg::QDEPTH);
   assign empty = count_ff == '0;
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop)
         count_in = count_ff + sbck_pkg::QCNT_W'(1);
      else if (pop && !push)
         count_in = count_ff - sbck_pkg::QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push)
         store_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= wr_ptr_ff + sbck_pkg::QPTR_W'(1);
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + sbck_pkg::QPTR_W'(1);
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/core/sbck_back.sv =====
// Back end: frame index multiply, sticky hit flag and the result register.
// Depends on sbck_pkg; drains sbck_queue.
module sbck_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [11:0]                 screen_width,
   input  logic                        q_empty,
   input  sbck_pkg::entry_type         q_head,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [47:0]                 rsp_tdata,
   output logic [1:0]                  rsp_tuser,
   output logic                        rsp_tlast
);

   logic [sbck_pkg::DIM_W-1:0] sw;
   logic [sbck_pkg::DEST_W:0]  prod;
   logic [sbck_pkg::DEST_W-1:0] dest_in;
   logic hit_ff, hit_in;

   logic        valid_ff;
   logic        we_ff, off_ff, last_ff;
   logic [1:0]  buf_ff;
   logic [sbck_pkg::DEST_W-1:0] dest_ff;
   logic [sbck_pkg::PIX_W-1:0]  pix_ff;

   assign q_pop = !q_empty && (!valid_ff || rsp_tready);

   always_comb begin
      sw   = sbck_pkg::clamp_dim(screen_width, sbck_pkg::DIM_W'(sbck_pkg::MAX_SCREEN_DIM));
      prod = (sbck_pkg::DEST_W+1)'(q_head.row * sw) +
             (sbck_pkg::DEST_W+1)'(q_head.col);
      dest_in = q_head.visible ? prod[sbck_pkg::DEST_W-1:0] : '0;
      // flag restarts with each sprite
      hit_in = (q_head.first ? 1'b0 : hit_ff) | q_head.hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         if (q_pop) begin
            valid_ff <= 1'b1;
            hit_ff   <= hit_in;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         we_ff   <= q_head.write_enable;
         buf_ff  <= q_head.buffer_id;
         dest_ff <= dest_in;
         pix_ff  <= q_head.pixel;
         off_ff  <= q_head.off_screen;
         last_ff <= q_head.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, off_ff, hit_ff, pix_ff, dest_ff, we_ff};
   assign rsp_tuser  = buf_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== rtl/core/sprite_blit_colour_key_clip.sv =====
// Top level of the colour-keyed sprite blitter: register file, front end,
// queue and back end. Depends on sbck_pkg, sbck_front, sbck_queue, sbck_back.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | tdata: sprite_pixel, background_pixel
//   rsp     | out | rsp_tvalid/rsp_tready | tdata, tuser = buffer_id, tlast = last
//   csr     | in  | csr_we                | csr_index, csr_wdata
//
// One pixel per clock sustained while rsp_tready is high; each request is written
// to the queue, then goes through the index multiply into the result register.
// Synchronous reset clears counters, hit flag and queue; sets register defaults.
// The four-entry queue keeps taking pixels while the result is stalled,
// and drops req_tready only once it is full.
module sprite_blit_colour_key_clip (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] sprite_pixel, [31:16] background_pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [0] write_enable, [22:1] dest_index,
                                    // [38:23] pixel_out, [39] collision,
                                    // [40] off_screen, [47:41] zero
   output logic [1:0]  rsp_tuser,   // [1:0] buffer_id
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   sbck_pkg::cfg_type   cfg_ff;
   sbck_pkg::entry_type fe_entry, q_head;
   logic q_full, q_empty, q_pop, accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sprite_width  <= 11'd1;
         cfg_ff.sprite_height <= 11'd1;
         cfg_ff.pos_x         <= '0;
         cfg_ff.pos_y         <= '0;
         cfg_ff.alignment     <= sbck_pkg::ALIGN_LEFT;
         cfg_ff.operation     <= sbck_pkg::OP_KEY_DISPLAY;
         cfg_ff.screen_width  <= 12'd1024;
         cfg_ff.screen_height <= 12'd768;
      end else if (csr_we) begin
         case (csr_index)
            sbck_pkg::REG_SPRITE_WIDTH:  cfg_ff.sprite_width  <= csr_wdata[10:0];
            sbck_pkg::REG_SPRITE_HEIGHT: cfg_ff.sprite_height <= csr_wdata[10:0];
            sbck_pkg::REG_POS_X:         cfg_ff.pos_x         <= $signed(csr_wdata);
            sbck_pkg::REG_POS_Y:         cfg_ff.pos_y         <= $signed(csr_wdata);
            sbck_pkg::REG_ALIGNMENT:     cfg_ff.alignment     <= csr_wdata[1:0];
            sbck_pkg::REG_OPERATION:     cfg_ff.operation     <= csr_wdata[1:0];
            sbck_pkg::REG_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_wdata;
            sbck_pkg::REG_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   sbck_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .accept           (accept),
      .sprite_pixel     (req_tdata[15:0]),
      .background_pixel (req_tdata[31:16]),
      .entry            (fe_entry)
   );

   sbck_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (fe_entry),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   sbck_back u_back (
      .clock        (clock),
      .reset        (reset),
      .screen_width (cfg_ff.screen_width),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

// ===== rtl/core/sbck_checker.sv =====
// Port-level checks for the sprite blitter, bound to the top level.
// Depends only on the top level's ports.
module sbck_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // after reset the queue is empty and open
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("bad state after reset");

   a_buffer_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("buffer id out of range");

   // bits above the packed fields stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:41] == 7'd0)
      else $error("tdata padding not zero");

endmodule

bind sprite_blit_colour_key_clip sbck_checker u_sbck_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sprite_blit_colour_key_clip: directed table, then random settings.
// Expected results: in-bench predictor or hand-typed rows. Depends on sbck_pkg and the RTL only.
module tb;

   localparam int RANDOM_ITEMS = 650;
   localparam int QUIET_FROM   = 560;
   localparam int HOLD_CYCLES  = 60;
   localparam int LIMIT_CYCLES = 200000;

   typedef struct packed {
      logic        we;
      logic [1:0]  buf_id;
      logic [21:0] dest;
      logic [15:0] pix;
      logic        hit;
      logic        off;
      logic        last;
   } blit_result_type;

   typedef struct packed {
      logic            is_csr;
      logic [2:0]      idx;
      logic [11:0]     val;
      logic [15:0]     spr;
      logic [15:0]     bg;
      logic            typed;
      blit_result_type res;
   } step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [15:0] sprite_pixel, [31:16] background_pixel
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;       // [0] write_enable, [22:1] dest_index, [38:23] pixel_out,
                                 // [39] collision, [40] off_screen, [47:41] zero
   logic [1:0]  rsp_tuser;       // [1:0] buffer_id
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [11:0] csr_wdata = '0;

   // predictor state
   sbck_pkg::cfg_type shadow;
   int                col_pos, row_pos;
   logic              hit_seen;
   blit_result_type   pending_blits[$];
   step_type          directed_steps[$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  checked_count = 0;
   bit  quiet = 1'b0;
   bit  hold_req = 1'b0;

   sprite_blit_colour_key_clip uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int dim_or_one(input int v, input int maxv);
      int r;
      r = (v == 0) ? 1 : v;
      if (r > maxv) r = maxv;
      return r;
   endfunction

   // one pixel through the blitter: position, clip, key test, counters
   function automatic blit_result_type blit_pixel(input logic [15:0] spr,
                                                  input logic [15:0] bg);
      blit_result_type r;
      int w, h, sw, sh, x, y, col, row;
      logic visible;
      w  = dim_or_one(shadow.sprite_width, sbck_pkg::MAX_SPRITE_DIM);
      h  = dim_or_one(shadow.sprite_height, sbck_pkg::MAX_SPRITE_DIM);
      sw = dim_or_one(shadow.screen_width, sbck_pkg::MAX_SCREEN_DIM);
      sh = dim_or_one(shadow.screen_height, sbck_pkg::MAX_SCREEN_DIM);
      x  = int'($signed(shadow.pos_x));
      y  = int'($signed(shadow.pos_y));
      if (shadow.operation != sbck_pkg::OP_COLLIDE) begin
         if (shadow.alignment == sbck_pkg::ALIGN_CENTRE) x = x - w / 2;
         else if (shadow.alignment == sbck_pkg::ALIGN_END) x = x - w;
      end
      r = '0;
      r.off = (x + w <= 0) || (x >= sw) || (y + h <= 0) || (y >= sh);
      col = x + col_pos;
      row = y + h - 1 - row_pos;
      visible = col >= 0 && col < sw && row >= 0 && row < sh;
      if (visible) r.dest = 22'(row * sw + col);
      if (col_pos == 0 && row_pos == 0) hit_seen = 1'b0;
      case (shadow.operation)
         sbck_pkg::OP_COLLIDE: begin
            r.we = 1'b0;
            if (visible && spr != sbck_pkg::KEY_COLOUR && bg != sbck_pkg::KEY_COLOUR)
               hit_seen = 1'b1;
         end
         sbck_pkg::OP_OPAQUE: r.we = visible;
         default: r.we = visible && spr != sbck_pkg::KEY_COLOUR;
      endcase
      r.buf_id = (shadow.operation == sbck_pkg::OP_OPAQUE ||
                  shadow.operation == sbck_pkg::OP_COLLIDE) ?
                 sbck_pkg::BUF_THIRD : shadow.operation;
      // counters may exceed the new size after a register change
      if (col_pos >= w - 1) begin
         col_pos = 0;
         if (row_pos >= h - 1) begin
            row_pos = 0;
            r.last = 1'b1;
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
      r.pix = spr;
      r.hit = hit_seen;
      return r;
   endfunction

   function automatic logic [15:0] pick_pixel();
      logic [15:0] p;
      case ($urandom_range(0, 15))
         0, 1, 2, 3: p = sbck_pkg::KEY_COLOUR;
         4: p = 16'h0000;
         5: p = 16'hFFFF;
         default: p = 16'($urandom);
      endcase
      return p;
   endfunction

   function automatic void add_csr(input logic [2:0] idx, input logic [11:0] val);
      step_type s;
      s = '0;
      s.is_csr = 1'b1;
      s.idx = idx;
      s.val = val;
      directed_steps.push_back(s);
   endfunction

   function automatic void add_pix(input logic [15:0] spr, input logic [15:0] bg);
      step_type s;
      s = '0;
      s.spr = spr;
      s.bg = bg;
      directed_steps.push_back(s);
   endfunction

   // typed rows are all single-pixel sprites: dest 0 and last set
   function automatic void add_pix_exp(input logic [15:0] spr, input logic [15:0] bg,
                                       input logic we, input logic [1:0] buf_id,
                                       input logic hit, input logic off);
      step_type s;
      s = '0;
      s.spr = spr;
      s.bg = bg;
      s.typed = 1'b1;
      s.res.we = we;
      s.res.buf_id = buf_id;
      s.res.pix = spr;
      s.res.hit = hit;
      s.res.off = off;
      s.res.last = 1'b1;
      directed_steps.push_back(s);
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [11:0] val);
      if (req_tvalid) req_tvalid <= 1'b0;
      while (pending_blits.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         sbck_pkg::REG_SPRITE_WIDTH:  shadow.sprite_width = val[10:0];
         sbck_pkg::REG_SPRITE_HEIGHT: shadow.sprite_height = val[10:0];
         sbck_pkg::REG_POS_X:         shadow.pos_x = val;
         sbck_pkg::REG_POS_Y:         shadow.pos_y = val;
         sbck_pkg::REG_ALIGNMENT:     shadow.alignment = val[1:0];
         sbck_pkg::REG_OPERATION:     shadow.operation = val[1:0];
         sbck_pkg::REG_SCREEN_WIDTH:  shadow.screen_width = val;
         default:                     shadow.screen_height = val;
      endcase
   endtask

   task automatic send_pixel(input logic [15:0] spr, input logic [15:0] bg,
                             input logic typed, input blit_result_type typed_res);
      blit_result_type predicted;
      csr_we <= 1'b0;
      if (!quiet && !hold_req && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {bg, spr};
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = blit_pixel(spr, bg);
      pending_blits.push_back(typed ? typed_res : predicted);
   endtask

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_blits.size() == 0) begin
            $display("%0t: result transaction with nothing expected, actual tdata 0x%0h",
                     $time, rsp_tdata);
            error_count++;
         end else begin
            blit_result_type e;
            e = pending_blits.pop_front();
            check_field("write_enable", e.we, rsp_tdata[0]);
            check_field("buffer_id", e.buf_id, rsp_tuser);
            check_field("dest_index", e.dest, rsp_tdata[22:1]);
            check_field("pixel_out", e.pix, rsp_tdata[38:23]);
            check_field("collision", e.hit, rsp_tdata[39]);
            check_field("off_screen", e.off, rsp_tdata[40]);
            check_field("last", e.last, rsp_tlast);
            checked_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: timeout, %0d results still expected", $time, pending_blits.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off to fill the block
   initial begin : rsp_side
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int w, h, burst, span, k, random_sent, settings, directed_pixels;
      logic [2:0] idx;
      logic [11:0] val;
      bit first_setting;
      random_sent = 0;
      settings = 1;
      directed_pixels = 0;
      first_setting = 1'b1;
      shadow = '0;
      shadow.sprite_width = 11'd1;
      shadow.sprite_height = 11'd1;
      shadow.screen_width = 12'd1024;
      shadow.screen_height = 12'd768;
      col_pos = 0;
      row_pos = 0;
      hit_seen = 1'b0;

      // values after reset
      add_pix_exp(16'h1234, 16'h0000, 1'b1, sbck_pkg::OP_KEY_DISPLAY, 1'b0, 1'b0);
      add_pix_exp(sbck_pkg::KEY_COLOUR, 16'h0000, 1'b0, sbck_pkg::OP_KEY_DISPLAY, 1'b0, 1'b0);
      add_pix_exp(16'hFFFF, 16'hFFFF, 1'b1, sbck_pkg::OP_KEY_DISPLAY, 1'b0, 1'b0);
      // collision: hit flag restarts with every one-pixel sprite
      add_csr(sbck_pkg::REG_OPERATION, 12'(sbck_pkg::OP_COLLIDE));
      add_pix_exp(16'h0000, 16'h0000, 1'b0, sbck_pkg::BUF_THIRD, 1'b1, 1'b0);
      add_pix_exp(sbck_pkg::KEY_COLOUR, 16'h0000, 1'b0, sbck_pkg::BUF_THIRD, 1'b0, 1'b0);
      add_pix_exp(16'h0000, sbck_pkg::KEY_COLOUR, 1'b0, sbck_pkg::BUF_THIRD, 1'b0, 1'b0);
      add_csr(sbck_pkg::REG_OPERATION, 12'(sbck_pkg::OP_OPAQUE));
      add_pix_exp(sbck_pkg::KEY_COLOUR, 16'h0000, 1'b1, sbck_pkg::BUF_THIRD, 1'b0, 1'b0);
      add_csr(sbck_pkg::REG_OPERATION, 12'(sbck_pkg::OP_KEY_BACK));
      add_csr(sbck_pkg::REG_POS_X, 12'h800);
      add_pix_exp(16'h0001, 16'h0000, 1'b0, sbck_pkg::OP_KEY_BACK, 1'b0, 1'b1);
      // zero screen width counts as one
      add_csr(sbck_pkg::REG_POS_X, 12'h7FF);
      add_csr(sbck_pkg::REG_SCREEN_WIDTH, 12'd0);
      add_pix(16'h07E0, 16'h001F);
      // oversized screen saturates; bottom-right corner of the largest frame
      add_csr(sbck_pkg::REG_POS_X, 12'h7FF);
      add_csr(sbck_pkg::REG_SCREEN_WIDTH, 12'hFFF);
      add_csr(sbck_pkg::REG_SCREEN_HEIGHT, 12'hFFF);
      add_csr(sbck_pkg::REG_POS_Y, 12'h7FF);
      add_csr(sbck_pkg::REG_OPERATION, 12'(sbck_pkg::OP_KEY_DISPLAY));
      add_pix(16'hF800, 16'h0000);
      // 3x2 sprite, centred, clipped on left and bottom of a 2x1 screen
      add_csr(sbck_pkg::REG_SPRITE_WIDTH, 12'd3);
      add_csr(sbck_pkg::REG_SPRITE_HEIGHT, 12'd2);
      add_csr(sbck_pkg::REG_ALIGNMENT, 12'(sbck_pkg::ALIGN_CENTRE));
      add_csr(sbck_pkg::REG_POS_X, 12'd0);
      add_csr(sbck_pkg::REG_POS_Y, 12'd0);
      add_csr(sbck_pkg::REG_SCREEN_WIDTH, 12'd2);
      add_csr(sbck_pkg::REG_SCREEN_HEIGHT, 12'd1);
      add_pix(16'h1111, 16'h0000);
      add_pix(sbck_pkg::KEY_COLOUR, 16'h0000);
      add_pix(16'h2222, 16'h0000);
      add_pix(16'h3333, 16'h0000);
      add_pix(16'h4444, 16'h0000);
      add_pix(sbck_pkg::KEY_COLOUR, 16'h0000);
      // collision ignores alignment
      add_csr(sbck_pkg::REG_ALIGNMENT, 12'(sbck_pkg::ALIGN_END));
      add_csr(sbck_pkg::REG_OPERATION, 12'(sbck_pkg::OP_COLLIDE));
      add_pix(16'h5555, sbck_pkg::KEY_COLOUR);
      add_pix(16'h6666, 16'h0001);
      add_pix(sbck_pkg::KEY_COLOUR, 16'h0002);
      // unused alignment code acts as left; stop half way into the sprite
      add_csr(sbck_pkg::REG_ALIGNMENT, 12'd3);
      add_csr(sbck_pkg::REG_OPERATION, 12'(sbck_pkg::OP_OPAQUE));
      add_pix(16'h7777, 16'h0000);
      add_pix(sbck_pkg::KEY_COLOUR, 16'h0000);
      // zero sprite size counts as one; row counter already past it
      add_csr(sbck_pkg::REG_SPRITE_WIDTH, 12'd0);
      add_csr(sbck_pkg::REG_SPRITE_HEIGHT, 12'd0);
      add_pix(16'h8888, 16'h0000);
      // oversized sprite saturates, far above the top
      add_csr(sbck_pkg::REG_SPRITE_WIDTH, 12'h7FF);
      add_csr(sbck_pkg::REG_SPRITE_HEIGHT, 12'h7FF);
      add_csr(sbck_pkg::REG_POS_Y, 12'h800);
      add_pix(16'h9999, 16'h0000);
      add_pix(16'hAAAA, 16'h0000);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_csr) begin
            csr_write(directed_steps[i].idx, directed_steps[i].val);
         end else begin
            send_pixel(directed_steps[i].spr, directed_steps[i].bg,
                       directed_steps[i].typed, directed_steps[i].res);
            directed_pixels++;
         end
      end

      while (random_sent < RANDOM_ITEMS) begin
         // screen size first so positions can be aimed at its edges
         for (k = 0; k < 8; k++) begin
            idx = 3'(k + 6);
            if (first_setting || $urandom_range(0, 1) == 1) begin
               case (idx)
                  sbck_pkg::REG_SPRITE_WIDTH, sbck_pkg::REG_SPRITE_HEIGHT: begin
                     case ($urandom_range(0, 19))
                        0: val[10:0] = 11'd0;
                        1: val[10:0] = 11'h7FF;
                        2: val[10:0] = 11'($urandom_range(1025, 2046));
                        3: val[10:0] = 11'd1024;
                        4, 5, 6: val[10:0] = 11'($urandom_range(9, 40));
                        default: val[10:0] = 11'($urandom_range(1, 8));
                     endcase
                     val[11] = 1'($urandom);
                  end
                  sbck_pkg::REG_SCREEN_WIDTH, sbck_pkg::REG_SCREEN_HEIGHT: begin
                     case ($urandom_range(0, 19))
                        0: val = 12'd0;
                        1: val = 12'hFFF;
                        2: val = 12'd2048;
                        3: val = 12'($urandom_range(2049, 4094));
                        4, 5: val = 12'($urandom);
                        default: val = 12'($urandom_range(1, 64));
                     endcase
                  end
                  sbck_pkg::REG_POS_X, sbck_pkg::REG_POS_Y: begin
                     span = dim_or_one(idx == sbck_pkg::REG_POS_X ? shadow.screen_width :
                                       shadow.screen_height, sbck_pkg::MAX_SCREEN_DIM);
                     case ($urandom_range(0, 9))
                        0: val = 12'h800;
                        1: val = 12'h7FF;
                        2: val = 12'($urandom);
                        default: val = 12'(int'($urandom_range(0, span + 40)) - 20);
                     endcase
                  end
                  default: val = 12'($urandom);   // alignment and operation use the low bits
               endcase
               csr_write(idx, val);
            end
         end
         w = dim_or_one(shadow.sprite_width, sbck_pkg::MAX_SPRITE_DIM);
         h = dim_or_one(shadow.sprite_height, sbck_pkg::MAX_SPRITE_DIM);
         burst = w * h;
         if (burst > 48) burst = $urandom_range(5, 48);
         else burst = burst * $urandom_range(1, 3);
         if (first_setting) begin
            // long result stall while pixels keep coming
            if (burst < 40) burst = 40;
            hold_req = 1'b1;
         end
         first_setting = 1'b0;
         settings++;
         repeat (burst) begin
            quiet = (random_sent >= QUIET_FROM);
            send_pixel(pick_pixel(), pick_pixel(), 1'b0, '0);
            random_sent++;
         end
      end

      req_tvalid <= 1'b0;
      while (pending_blits.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d directed and %0d random pixels over %0d register settings,",
               directed_pixels, random_sent, settings);
      $display("all operations and alignments, clipping on every edge; %0d results checked.",
               checked_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sprite_blit_colour_key_clip.f =====
rtl/core/sbck_pkg.sv
rtl/core/sbck_front.sv
rtl/core/sbck_queue.sv
rtl/core/sbck_back.sv
rtl/core/sprite_blit_colour_key_clip.sv
rtl/core/sbck_checker.sv
dv/tb.sv
